>>> hw/rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define RRTS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define RRTS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/rrts_pkg.sv
package rrts_pkg;

    localparam int OP_W     = 3;
    localparam int TASK_W   = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 8;
    localparam logic [CFG_W-1:0] TSLICE_RESET = 8'd10;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_YIELD   = 3'd1,
        OP_BLOCK   = 3'd2,
        OP_UNBLOCK = 3'd3,
        OP_EXIT    = 3'd4,
        OP_ADD     = 3'd5,
        OP_REMOVE  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        TS_READY   = 2'd0,
        TS_RUNNING = 2'd1,
        TS_BLOCKED = 2'd2,
        TS_DEAD    = 2'd3
    } task_state_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_NO_RUN  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TICK,
        S_ADD_A,
        S_ADD_B,
        S_RM_FIRST,
        S_RM_WALK,
        S_RS_START,
        S_RS_FIRST,
        S_RS_WALK,
        S_RS_DEMOTE,
        S_FIN
    } fsm_t;

endpackage

>>> hw/rtl/rrts_in_if.sv
interface rrts_in_if;
    import rrts_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [TASK_W-1:0] task_req;
    logic              make_current;

    modport source (output valid, output op, output task_req, output make_current,
                    input ready);
    modport sink (input valid, input op, input task_req, input make_current,
                  output ready);
endinterface

>>> hw/rtl/rrts_out_if.sv
interface rrts_out_if;
    import rrts_pkg::*;

    logic                valid;
    logic                ready;
    logic                switched;
    logic [TASK_W-1:0]   from_task;
    logic [TASK_W-1:0]   to_task;
    logic [TASK_W-1:0]   running_task;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output switched, output from_task, output to_task,
                    output running_task, output status, input ready);
    modport sink (input valid, input switched, input from_task, input to_task,
                  input running_task, input status, output ready);
endinterface

>>> hw/rtl/round_robin_task_scheduler_top.sv
// channel | dir | handshake          | payload
// evt     | in  | valid/ready        | op, task_req, make_current
// res     | out | valid/ready        | switched, from_task, to_task, running_task, status
// cfg     | in  | cfg_we, no wait    | cfg_wdata = default_timeslice
//
// one event at a time; a ring walk, when one runs, steps one slot per cycle through the
// successor and state memories
// rst_n clears queue marks, state valid bits, ring and current-task registers at once
// a finished item waits in the output register while the next event is accepted;
// the sequencer stalls at its last step until that register is taken
module round_robin_task_scheduler_top #(
    parameter int MAX_TASKS  = 16,
    parameter int SLICE_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    rrts_in_if.sink                  evt,
    rrts_out_if.source               res,
    input  logic                     cfg_we,
    input  logic [rrts_pkg::CFG_W-1:0] cfg_wdata
);
    import rrts_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam logic [IDX_W-1:0] WALK_LAST = IDX_W'(MAX_TASKS - 1);

    fsm_t                 state_reg, state_next;
    logic [CFG_W-1:0]     tslice_reg;
    op_t                  op_reg, op_next;
    logic [TASK_W-1:0]    t_reg, t_next;
    logic                 mk_reg, mk_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic                 nonempty_reg, nonempty_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic                 cur_vld_reg, cur_vld_next;
    logic [MAX_TASKS-1:0] queued_reg, queued_next;
    logic [MAX_TASKS-1:0] st_vld_reg;
    logic                 st_rd_vld_reg;
    logic [IDX_W-1:0]     n_reg, n_next;
    logic [IDX_W-1:0]     start_reg, start_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     prev_reg, prev_next;
    logic                 demote_reg, demote_next;
    logic                 had_reg, had_next;
    logic                 pend_sw_reg, pend_sw_next;
    status_t              pend_status_reg, pend_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_sw_reg, out_sw_next;
    logic [TASK_W-1:0]    out_from_reg, out_from_next;
    logic [TASK_W-1:0]    out_to_reg, out_to_next;
    logic [TASK_W-1:0]    out_run_reg, out_run_next;
    status_t              out_status_reg, out_status_next;

    logic                  succ_we;
    logic [IDX_W-1:0]      succ_waddr, succ_wdata, succ_raddr, succ_rdata;
    logic                  st_we;
    logic [IDX_W-1:0]      st_waddr, st_raddr;
    task_state_t           st_wdata;
    logic [1:0]            st_rdata;
    logic                  sl_we;
    logic [IDX_W-1:0]      sl_waddr, sl_raddr;
    logic [SLICE_BITS-1:0] sl_wdata, sl_rdata;

    logic [IDX_W-1:0]      t_idx;
    logic                  t_ok;
    logic                  q_t;
    logic [SLICE_BITS-1:0] reload;
    task_state_t           rd_state;
    logic                  rd_runnable;
    logic                  walk_last;
    logic                  rm_hit, rm_stop, rs_stop, found_self, tick_resched;
    logic                  out_free;

    rrts_ram #(.WIDTH(IDX_W), .DEPTH(MAX_TASKS)) u_succ_ram (
        .clk   (clk),
        .we    (succ_we),
        .waddr (succ_waddr),
        .wdata (succ_wdata),
        .raddr (succ_raddr),
        .rdata (succ_rdata)
    );

    rrts_ram #(.WIDTH(2), .DEPTH(MAX_TASKS)) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    rrts_ram #(.WIDTH(SLICE_BITS), .DEPTH(MAX_TASKS)) u_slice_ram (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    assign t_idx        = IDX_W'(t_reg);
    assign t_ok         = 32'(t_reg) < MAX_TASKS;
    assign q_t          = t_ok && queued_reg[t_idx];
    assign reload       = SLICE_BITS'(tslice_reg);
    // a state entry never written reads as ready
    assign rd_state     = st_rd_vld_reg ? task_state_t'(st_rdata) : TS_READY;
    assign rd_runnable  = (rd_state == TS_READY) || (rd_state == TS_RUNNING);
    assign walk_last    = (cnt_reg == WALK_LAST);
    assign rm_hit       = (succ_rdata == t_idx);
    assign rm_stop      = (succ_rdata == head_reg) || walk_last;
    assign rs_stop      = (succ_rdata == start_reg) || walk_last;
    assign found_self   = (n_reg == cur_reg);
    assign tick_resched = (sl_rdata < SLICE_BITS'(2));
    assign out_free     = !out_valid_reg || res.ready;

    assign evt.ready        = (state_reg == S_IDLE);
    assign res.valid        = out_valid_reg;
    assign res.switched     = out_sw_reg;
    assign res.from_task    = out_from_reg;
    assign res.to_task      = out_to_reg;
    assign res.running_task = out_run_reg;
    assign res.status       = out_status_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (evt.valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (op_reg)
                    OP_TICK:    state_next = cur_vld_reg ? S_TICK : S_FIN;
                    OP_YIELD:   state_next = cur_vld_reg ? S_RS_START : S_FIN;
                    OP_BLOCK:   state_next = (t_ok && cur_vld_reg && t_idx == cur_reg)
                                             ? S_RS_START : S_FIN;
                    OP_UNBLOCK: state_next = S_FIN;
                    OP_EXIT:    state_next = cur_vld_reg ? S_RS_START : S_FIN;
                    OP_ADD:     state_next = (t_ok && !q_t) ? S_ADD_A : S_FIN;
                    OP_REMOVE:  state_next = (t_ok && nonempty_reg && q_t) ? S_RM_FIRST : S_FIN;
                    default:    state_next = S_FIN;
                endcase
            end
            S_TICK:      state_next = tick_resched ? S_RS_START : S_FIN;
            S_ADD_A:     state_next = S_ADD_B;
            S_ADD_B:     state_next = S_FIN;
            S_RM_FIRST:  state_next = rm_hit ? S_FIN : S_RM_WALK;
            S_RM_WALK:   state_next = (rm_hit || rm_stop) ? S_FIN : S_RM_WALK;
            S_RS_START:  state_next = (cur_vld_reg && nonempty_reg) ? S_RS_FIRST : S_FIN;
            S_RS_FIRST:  state_next = S_RS_WALK;
            S_RS_WALK:
            begin
                if (rd_runnable)
                begin
                    state_next = (!found_self && demote_reg) ? S_RS_DEMOTE : S_FIN;
                end
                else
                begin
                    state_next = rs_stop ? S_FIN : S_RS_WALK;
                end
            end
            S_RS_DEMOTE: state_next = S_FIN;
            S_FIN:       state_next = out_free ? S_IDLE : S_FIN;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        succ_we          = 1'b0;
        succ_waddr       = t_idx;
        succ_wdata       = t_idx;
        succ_raddr       = n_reg;
        st_we            = 1'b0;
        st_waddr         = t_idx;
        st_wdata         = TS_READY;
        st_raddr         = n_reg;
        sl_we            = 1'b0;
        sl_waddr         = t_idx;
        sl_wdata         = reload;
        sl_raddr         = cur_reg;
        op_next          = op_reg;
        t_next           = t_reg;
        mk_next          = mk_reg;
        head_next        = head_reg;
        nonempty_next    = nonempty_reg;
        cur_next         = cur_reg;
        cur_vld_next     = cur_vld_reg;
        queued_next      = queued_reg;
        n_next           = n_reg;
        start_next       = start_reg;
        cnt_next         = cnt_reg;
        prev_next        = prev_reg;
        demote_next      = demote_reg;
        had_next         = had_reg;
        pend_sw_next     = pend_sw_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_sw_next      = out_sw_reg;
        out_from_next    = out_from_reg;
        out_to_next      = out_to_reg;
        out_run_next     = out_run_reg;
        out_status_next  = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (evt.valid)
                begin
                    op_next      = op_t'(evt.op);
                    t_next       = evt.task_req;
                    mk_next      = evt.make_current;
                    pend_sw_next = 1'b0;
                end
            end
            S_DECODE:
            begin
                pend_status_next = STAT_DONE;
                case (op_reg)
                    OP_TICK:
                    begin
                        if (!cur_vld_reg)
                        begin
                            pend_status_next = STAT_IGNORED;
                        end
                    end
                    OP_YIELD:
                    begin
                        if (!cur_vld_reg)
                        begin
                            pend_status_next = STAT_IGNORED;
                        end
                        else
                        begin
                            sl_we    = 1'b1;
                            sl_waddr = cur_reg;
                            sl_wdata = '0;
                        end
                    end
                    OP_BLOCK:
                    begin
                        if (!t_ok)
                        begin
                            pend_status_next = STAT_IGNORED;
                        end
                        else
                        begin
                            st_we    = 1'b1;
                            st_wdata = TS_BLOCKED;
                        end
                    end
                    OP_UNBLOCK:
                    begin
                        if (!t_ok)
                        begin
                            pend_status_next = STAT_IGNORED;
                        end
                        else
                        begin
                            st_we    = 1'b1;
                            st_wdata = TS_READY;
                            sl_we    = 1'b1;
                        end
                    end
                    OP_EXIT:
                    begin
                        if (!cur_vld_reg)
                        begin
                            pend_status_next = STAT_IGNORED;
                        end
                        else
                        begin
                            st_we    = 1'b1;
                            st_waddr = cur_reg;
                            st_wdata = TS_DEAD;
                        end
                    end
                    OP_ADD:
                    begin
                        if (!t_ok || q_t)
                        begin
                            pend_status_next = STAT_IGNORED;
                        end
                        else
                        begin
                            succ_raddr         = head_reg;
                            st_raddr           = cur_reg;
                            sl_we              = 1'b1;
                            queued_next[t_idx] = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!t_ok || !nonempty_reg || !q_t)
                        begin
                            pend_status_next = STAT_IGNORED;
                        end
                        else
                        begin
                            succ_raddr = t_idx;
                        end
                    end
                    default:
                    begin
                        pend_status_next = STAT_IGNORED;
                    end
                endcase
            end
            S_TICK:
            begin
                if (sl_rdata != '0)
                begin
                    sl_we    = 1'b1;
                    sl_waddr = cur_reg;
                    sl_wdata = sl_rdata - 1'b1;
                end
            end
            S_ADD_A:
            begin
                // link in after the head, or start a new ring
                succ_we = 1'b1;
                if (nonempty_reg)
                begin
                    succ_wdata = succ_rdata;
                end
                else
                begin
                    head_next     = t_idx;
                    nonempty_next = 1'b1;
                end
                st_we       = 1'b1;
                st_wdata    = mk_reg ? TS_RUNNING : TS_READY;
                had_next    = nonempty_reg;
                demote_next = mk_reg && cur_vld_reg && (cur_reg != t_idx)
                              && (rd_state == TS_RUNNING);
            end
            S_ADD_B:
            begin
                if (had_reg)
                begin
                    succ_we    = 1'b1;
                    succ_waddr = head_reg;
                    succ_wdata = t_idx;
                end
                if (demote_reg)
                begin
                    st_we    = 1'b1;
                    st_waddr = cur_reg;
                    st_wdata = TS_READY;
                end
                if (mk_reg)
                begin
                    cur_next     = t_idx;
                    cur_vld_next = 1'b1;
                end
            end
            S_RM_FIRST:
            begin
                if (rm_hit)
                begin
                    // only member left
                    nonempty_next      = 1'b0;
                    queued_next[t_idx] = 1'b0;
                end
                else
                begin
                    start_next = succ_rdata;
                    n_next     = head_reg;
                    cnt_next   = '0;
                    succ_raddr = head_reg;
                end
            end
            S_RM_WALK:
            begin
                // n_reg is the candidate predecessor, succ_rdata its link
                if (rm_hit)
                begin
                    succ_we    = 1'b1;
                    succ_waddr = n_reg;
                    succ_wdata = start_reg;
                    if (head_reg == t_idx)
                    begin
                        head_next = start_reg;
                    end
                    queued_next[t_idx] = 1'b0;
                end
                else if (rm_stop)
                begin
                    pend_status_next = STAT_IGNORED;
                end
                else
                begin
                    n_next     = succ_rdata;
                    cnt_next   = cnt_reg + 1'b1;
                    succ_raddr = succ_rdata;
                end
            end
            S_RS_START:
            begin
                if (!cur_vld_reg || !nonempty_reg)
                begin
                    pend_status_next = STAT_IGNORED;
                end
                else
                begin
                    succ_raddr = cur_reg;
                    st_raddr   = cur_reg;
                end
            end
            S_RS_FIRST:
            begin
                start_next  = succ_rdata;
                n_next      = succ_rdata;
                cnt_next    = '0;
                demote_next = (rd_state == TS_RUNNING);
                succ_raddr  = succ_rdata;
                st_raddr    = succ_rdata;
            end
            S_RS_WALK:
            begin
                if (rd_runnable)
                begin
                    if (!found_self)
                    begin
                        st_we        = 1'b1;
                        st_waddr     = n_reg;
                        st_wdata     = TS_RUNNING;
                        sl_we        = 1'b1;
                        sl_waddr     = n_reg;
                        prev_next    = cur_reg;
                        cur_next     = n_reg;
                        pend_sw_next = 1'b1;
                    end
                end
                else if (rs_stop)
                begin
                    pend_status_next = STAT_NO_RUN;
                end
                else
                begin
                    n_next     = succ_rdata;
                    cnt_next   = cnt_reg + 1'b1;
                    succ_raddr = succ_rdata;
                    st_raddr   = succ_rdata;
                end
            end
            S_RS_DEMOTE:
            begin
                st_we    = 1'b1;
                st_waddr = prev_reg;
                st_wdata = TS_READY;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sw_next     = pend_sw_reg;
                    out_from_next   = pend_sw_reg ? TASK_W'(prev_reg) : '0;
                    out_to_next     = pend_sw_reg ? TASK_W'(cur_reg) : '0;
                    out_run_next    = cur_vld_reg ? TASK_W'(cur_reg) : '0;
                    out_status_next = pend_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tslice_reg    <= TSLICE_RESET;
            head_reg      <= '0;
            nonempty_reg  <= 1'b0;
            cur_reg       <= '0;
            cur_vld_reg   <= 1'b0;
            queued_reg    <= '0;
            st_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            nonempty_reg  <= nonempty_next;
            cur_reg       <= cur_next;
            cur_vld_reg   <= cur_vld_next;
            queued_reg    <= queued_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tslice_reg <= cfg_wdata;
            end
            if (st_we)
            begin
                st_vld_reg[st_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_rd_vld_reg   <= st_vld_reg[st_raddr];
        op_reg          <= op_next;
        t_reg           <= t_next;
        mk_reg          <= mk_next;
        n_reg           <= n_next;
        start_reg       <= start_next;
        cnt_reg         <= cnt_next;
        prev_reg        <= prev_next;
        demote_reg      <= demote_next;
        had_reg         <= had_next;
        pend_sw_reg     <= pend_sw_next;
        pend_status_reg <= pend_status_next;
        out_sw_reg      <= out_sw_next;
        out_from_reg    <= out_from_next;
        out_to_reg      <= out_to_next;
        out_run_reg     <= out_run_next;
        out_status_reg  <= out_status_next;
    end
endmodule

>>> hw/rtl/rrts_ram.sv
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/rrts_checker.sv
`include "assert_macros.svh"

module rrts_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          evt_valid,
    input logic                          evt_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic                          res_switched,
    input logic [rrts_pkg::TASK_W-1:0]   res_from_task,
    input logic [rrts_pkg::TASK_W-1:0]   res_to_task,
    input logic [rrts_pkg::TASK_W-1:0]   res_running_task,
    input logic [rrts_pkg::STATUS_W-1:0] res_status
);
    import rrts_pkg::*;

    // items accepted but not yet delivered
    logic [1:0] pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if ((evt_valid && evt_ready) && !(res_valid && res_ready))
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!(evt_valid && evt_ready) && (res_valid && res_ready))
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `RRTS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, evt_valid && evt_ready, !evt_ready)
    `RRTS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_switched) && $stable(res_from_task) && $stable(res_to_task) && $stable(res_running_task) && $stable(res_status))
    `RRTS_ASSERT_IMP(a_res_has_item, clk, rst_n, res_valid, pend_reg != 2'd0)
    `RRTS_ASSERT_IMP(a_ready_has_room, clk, rst_n, evt_ready, pend_reg == 2'd0 || pend_reg == 2'd1)
    `RRTS_ASSERT_IMP(a_switch_target, clk, rst_n, res_valid && res_switched, res_to_task == res_running_task && res_status == STAT_DONE)
endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .evt_valid        (evt.valid),
    .evt_ready        (evt.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_switched     (res.switched),
    .res_from_task    (res.from_task),
    .res_to_task      (res.to_task),
    .res_running_task (res.running_task),
    .res_status       (res.status)
);
